// ----- rtl/mla_pkg.sv -----
// mla_pkg: shared types and constants of the mean luma auto exposure block
// used by every module under rtl; depends on nothing

package mla_pkg;

    // field widths
    localparam int PIX_W    = 11;
    localparam int COLOR_W  = 8;
    localparam int LUMA_W   = 8;
    localparam int SUM_W    = 22;
    localparam int COUNT_W  = 14;
    localparam int EXP_W    = 16;
    localparam int SCALE_W  = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LOWER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_UPPER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_MIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_MAX      = 3'd4;

    // register and state reset values
    localparam logic [LUMA_W-1:0]  RST_BRIGHT_LOWER = 8'd100;
    localparam logic [LUMA_W-1:0]  RST_BRIGHT_UPPER = 8'd120;
    localparam logic [SCALE_W-1:0] RST_SCALE        = 11'd1050;
    localparam logic [EXP_W-1:0]   RST_EXP_MIN      = 16'd200;
    localparam logic [EXP_W-1:0]   RST_EXP_MAX      = 16'd40000;
    localparam logic [EXP_W-1:0]   RST_EXPOSURE     = 16'd3200;

    // default geometry
    localparam int DEF_FRAME_ROWS  = 512;
    localparam int DEF_FRAME_COLS  = 640;
    localparam int DEF_SAMPLE_STEP = 5;
    localparam int DEF_RADIUS      = 360;

    // frame summary queue, depth must be a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // luma weights and divide by 1000 through a reciprocal (exact below 2^18)
    localparam int PERMILLE  = 1000;
    localparam int WSUM_W    = 18;
    localparam int LUMA_S    = 28;
    localparam int LUMA_M    = 268436;
    localparam int LUMA_M_W  = 19;
    localparam int LUMA_PW   = WSUM_W + LUMA_M_W;

    // exposure times scale divided by 1000 through a reciprocal (exact below 2^27)
    localparam int SCALE_PROD_W = EXP_W + SCALE_W;
    localparam int RAISE_S      = 36;
    localparam int RAISE_M      = 68719477;
    localparam int RAISE_M_W    = 27;
    localparam int RAISE_PW     = SCALE_PROD_W + RAISE_M_W;
    localparam int RAISE_Q_W    = RAISE_PW - RAISE_S;

    // shared iterative divider
    localparam int DIV_NUM_W = 27;
    localparam int DIV_DEN_W = 14;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic [LUMA_W-1:0]  lower;
        logic [LUMA_W-1:0]  upper;
        logic [SCALE_W-1:0] scale;
        logic [EXP_W-1:0]   exp_min;
        logic [EXP_W-1:0]   exp_max;
    } cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } frame_sum_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

// ----- rtl/mla_front.sv -----
// mla_front: pixel intake, sampling grid and radius test, luma and accumulation
// depends on mla_pkg; pushes one frame summary per frame into the queue

module mla_front import mla_pkg::*; #(
    parameter int FRAME_ROWS  = DEF_FRAME_ROWS,
    parameter int FRAME_COLS  = DEF_FRAME_COLS,
    parameter int SAMPLE_STEP = DEF_SAMPLE_STEP,
    parameter int RADIUS      = DEF_RADIUS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PIX_W-1:0]   pix_row,
    input  logic [PIX_W-1:0]   pix_col,
    input  logic [COLOR_W-1:0] blue,
    input  logic [COLOR_W-1:0] green,
    input  logic [COLOR_W-1:0] red,
    input  logic               frame_end,
    input  logic [Q_CNT_W-1:0] q_count,
    output logic               push,
    output frame_sum_t         push_data
);

    // grid test: x is a multiple of the step when the low bits of x*m are below m
    localparam int STEP_L  = $clog2(SAMPLE_STEP);
    localparam int STEP_S  = PIX_W + STEP_L;
    localparam int STEP_M  = ((1 << STEP_S) + SAMPLE_STEP - 1) / SAMPLE_STEP;
    localparam int STEP_PW = PIX_W + STEP_S + 1;
    localparam int GEO_W   = PIX_W + 1;
    localparam int DIFF_W  = PIX_W + 2;
    localparam int DIST_W  = 24;
    localparam logic [DIST_W-1:0] RADIUS_SQ = DIST_W'(RADIUS * RADIUS);
    localparam logic [STEP_S:0]   STEP_M_V  = (STEP_S + 1)'(STEP_M);
    localparam logic [DIFF_W+1:0] FE_LIMIT  = (DIFF_W + 2)'(QUEUE_DEPTH);

    logic                 accept;
    logic [STEP_PW-1:0]   row_prod;
    logic [STEP_PW-1:0]   col_prod;
    logic                 row_div;
    logic                 col_div;
    logic                 in_bounds;
    logic signed [DIFF_W-1:0]   dr;
    logic signed [DIFF_W-1:0]   dc;
    logic signed [2*DIFF_W-1:0] dr_sq;
    logic signed [2*DIFF_W-1:0] dc_sq;
    logic [WSUM_W-1:0]    wsum;

    logic                 b_valid_reg;
    logic                 b_fe_reg;
    logic                 b_keep_reg;
    logic [WSUM_W-1:0]    b_w_reg;
    logic [DIST_W-1:0]    b_dr2_reg;
    logic [DIST_W-1:0]    b_dc2_reg;

    logic                 c_valid_reg;
    logic                 c_fe_reg;
    logic                 c_keep_reg;
    logic [LUMA_PW-1:0]   c_prod_reg;

    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic [LUMA_W-1:0]    luma;
    logic [SUM_W:0]       sum_wide;
    logic [1:0]           fe_inflight;
    logic [DIFF_W+1:0]    pending;

    // reserve a queue slot for every frame end still in the pipeline
    assign fe_inflight = {1'b0, b_valid_reg & b_fe_reg} + {1'b0, c_valid_reg & c_fe_reg};
    assign pending     = (DIFF_W + 2)'(q_count) + (DIFF_W + 2)'(fe_inflight);
    assign in_stall    = (pending >= FE_LIMIT);
    assign accept      = in_valid & ~in_stall;

    // first stage: grid products, distance squares, weighted color sum
    assign row_prod  = STEP_PW'(pix_row) * STEP_PW'(STEP_M);
    assign col_prod  = STEP_PW'(pix_col) * STEP_PW'(STEP_M);
    assign row_div   = ({1'b0, row_prod[STEP_S-1:0]} < STEP_M_V);
    assign col_div   = ({1'b0, col_prod[STEP_S-1:0]} < STEP_M_V);
    assign in_bounds = (GEO_W'(pix_row) < GEO_W'(FRAME_ROWS))
                     & (GEO_W'(pix_col) < GEO_W'(FRAME_COLS));
    assign dr    = $signed(DIFF_W'(pix_row) - DIFF_W'(FRAME_ROWS));
    assign dc    = $signed(DIFF_W'(pix_col) - DIFF_W'(FRAME_COLS));
    assign dr_sq = dr * dr;
    assign dc_sq = dc * dc;
    assign wsum  = WSUM_W'(red) * WSUM_W'(299) + WSUM_W'(green) * WSUM_W'(587)
                 + WSUM_W'(blue) * WSUM_W'(114);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_fe_reg    <= 1'b0;
        end
        else
        begin
            b_valid_reg <= accept;
            b_fe_reg    <= frame_end;
        end
    end

    always_ff @(posedge clk)
    begin
        b_keep_reg <= in_bounds & row_div & col_div;
        b_w_reg    <= wsum;
        b_dr2_reg  <= DIST_W'(dr_sq);
        b_dc2_reg  <= DIST_W'(dc_sq);
    end

    // second stage: radius test and reciprocal multiply for the divide by 1000
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            c_fe_reg    <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
            c_fe_reg    <= b_fe_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_keep_reg <= b_keep_reg & ((b_dr2_reg + b_dc2_reg) < RADIUS_SQ);
        c_prod_reg <= LUMA_PW'(b_w_reg) * LUMA_PW'(LUMA_M);
    end

    // third stage: saturating accumulation, summary push at frame end
    assign luma     = c_prod_reg[LUMA_S +: LUMA_W];
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(luma);

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (c_valid_reg && c_keep_reg)
        begin
            sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
            if (count_reg != {COUNT_W{1'b1}})
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    assign push            = c_valid_reg & c_fe_reg;
    assign push_data.sum   = sum_next;
    assign push_data.count = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (push)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/mla_queue.sv -----
// mla_queue: short queue of frame summaries between front and back
// depends on mla_pkg

module mla_queue import mla_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  frame_sum_t         push_data,
    input  logic               pop,
    output frame_sum_t         head,
    output logic               empty,
    output logic [Q_CNT_W-1:0] count
);

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    frame_sum_t         mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign head  = mem[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < Q_CNT_W'(DEPTH)))
        else $error("frame summary pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("frame summary popped from an empty queue");

endmodule

// ----- rtl/mla_div.sv -----
// mla_div: restoring divider, one quotient bit per cycle
// depends on mla_pkg; shared by the mean and the exposure scaling

module mla_div import mla_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;
    logic                 qbit;

    // trial subtract; a zero divisor yields an all ones quotient
    assign trial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient shifts into the numerator register
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], qbit};
            rem_reg <= qbit ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;

endmodule

// ----- rtl/mla_back.sv -----
// mla_back: per frame mean, exposure update and result register
// depends on mla_pkg and mla_div

module mla_back import mla_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  frame_sum_t         head,
    input  logic               empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [EXP_W-1:0]   exposure,
    output logic [LUMA_W-1:0]  mean_luma,
    output logic [COUNT_W-1:0] sample_count
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MEAN  = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_OUT   = 3'd3;
    localparam logic [2:0] ST_RAISE = 3'd4;
    localparam logic [2:0] ST_APPLY = 3'd5;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [EXP_W-1:0]        exposure_reg;
    logic [EXP_W-1:0]        exposure_next;
    logic [LUMA_W-1:0]       mean_reg;
    logic [LUMA_W-1:0]       mean_next;
    logic [COUNT_W-1:0]      count_reg;
    logic [COUNT_W-1:0]      count_next;
    logic [LUMA_W-1:0]       mean_c;
    logic                    in_band;
    logic [SCALE_PROD_W-1:0] raise_prod_reg;
    logic [RAISE_PW-1:0]     raise_recip_reg;
    logic [RAISE_Q_W-1:0]    raise_q;
    div_req_t                req;
    div_rsp_t                rsp;

    mla_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // clamp of the quotient to a luma value
    assign mean_c  = (rsp.quot > DIV_NUM_W'(255)) ? {LUMA_W{1'b1}} : rsp.quot[LUMA_W-1:0];
    assign in_band = (exposure_reg > cfg.exp_min) && (exposure_reg < cfg.exp_max);

    // raise path: exposure times scale, then a reciprocal multiply for the divide by 1000
    always_ff @(posedge clk)
    begin
        raise_prod_reg  <= SCALE_PROD_W'(exposure_reg) * SCALE_PROD_W'(cfg.scale);
        raise_recip_reg <= RAISE_PW'(raise_prod_reg) * RAISE_PW'(RAISE_M);
    end

    assign raise_q = raise_recip_reg[RAISE_S +: RAISE_Q_W];

    // frame sequencer
    always_comb
    begin
        state_next    = state_reg;
        exposure_next = exposure_reg;
        mean_next     = mean_reg;
        count_next    = count_reg;
        pop           = 1'b0;
        req.start     = 1'b0;
        req.num       = DIV_NUM_W'(head.sum);
        req.den       = head.count;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    count_next = head.count;
                    if (head.count == '0)
                    begin
                        mean_next  = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        req.start  = 1'b1;
                        state_next = ST_MEAN;
                    end
                end
            end
            ST_MEAN:
            begin
                if (rsp.done)
                begin
                    mean_next = mean_c;
                    if (in_band && (mean_c < cfg.lower))
                    begin
                        state_next = ST_RAISE;
                    end
                    else if (in_band && (mean_c > cfg.upper))
                    begin
                        req.start  = 1'b1;
                        req.num    = DIV_NUM_W'(exposure_reg) * DIV_NUM_W'(PERMILLE);
                        req.den    = DIV_DEN_W'(cfg.scale);
                        state_next = ST_SCALE;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_RAISE:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                exposure_next = (raise_q > RAISE_Q_W'({EXP_W{1'b1}}))
                              ? {EXP_W{1'b1}} : raise_q[EXP_W-1:0];
                state_next    = ST_OUT;
            end
            ST_SCALE:
            begin
                if (rsp.done)
                begin
                    exposure_next = (rsp.quot > DIV_NUM_W'({EXP_W{1'b1}}))
                                  ? {EXP_W{1'b1}} : rsp.quot[EXP_W-1:0];
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            exposure_reg <= RST_EXPOSURE;
        end
        else
        begin
            state_reg    <= state_next;
            exposure_reg <= exposure_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg  <= mean_next;
        count_reg <= count_next;
    end

    assign out_valid    = (state_reg == ST_OUT);
    assign exposure     = exposure_reg;
    assign mean_luma    = mean_reg;
    assign sample_count = count_reg;

    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !rsp.busy)
        else $error("divider started while busy");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> ((state_reg == ST_MEAN) || (state_reg == ST_SCALE)))
        else $error("divider finished with no division pending");

endmodule

// ----- rtl/mean_luma_auto_exposure.sv -----
// mean_luma_auto_exposure: top level, configuration registers and block wiring
// depends on mla_pkg, mla_front, mla_queue, mla_back
//
//  channel  direction  handshake             payload
//  pixel    in         in_valid / in_stall   pix_row pix_col blue green red frame_end
//  result   out        out_valid / out_stall exposure mean_luma sample_count
//  config   in         cfg_valid / cfg_ready cfg_index cfg_data
//
//  pixels: one transaction per cycle when not stalled, three stage front pipeline
//  result: out_valid follows the frame end through the front b and c registers, the
//  queue and the bit-serial mean divide, plus a second divide when exposure is lowered
//  in_stall rises only while the frame summary queue (4 frames) is fully reserved
//  reset restores the register defaults and an exposure of 3200, no clearing pass
//  cfg_ready is always high

module mean_luma_auto_exposure import mla_pkg::*; #(
    parameter int FRAME_ROWS  = DEF_FRAME_ROWS,
    parameter int FRAME_COLS  = DEF_FRAME_COLS,
    parameter int SAMPLE_STEP = DEF_SAMPLE_STEP,
    parameter int RADIUS      = DEF_RADIUS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pix_row,
    input  logic [PIX_W-1:0]      pix_col,
    input  logic [COLOR_W-1:0]    blue,
    input  logic [COLOR_W-1:0]    green,
    input  logic [COLOR_W-1:0]    red,
    input  logic                  frame_end,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [EXP_W-1:0]      exposure,
    output logic [LUMA_W-1:0]     mean_luma,
    output logic [COUNT_W-1:0]    sample_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg_reg;
    logic               push;
    frame_sum_t         push_data;
    logic               pop;
    frame_sum_t         head;
    logic               empty;
    logic [Q_CNT_W-1:0] q_count;

    // configuration register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower   <= RST_BRIGHT_LOWER;
            cfg_reg.upper   <= RST_BRIGHT_UPPER;
            cfg_reg.scale   <= RST_SCALE;
            cfg_reg.exp_min <= RST_EXP_MIN;
            cfg_reg.exp_max <= RST_EXP_MAX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BRIGHT_LOWER: cfg_reg.lower   <= cfg_data[LUMA_W-1:0];
                CFG_BRIGHT_UPPER: cfg_reg.upper   <= cfg_data[LUMA_W-1:0];
                CFG_SCALE:        cfg_reg.scale   <= cfg_data[SCALE_W-1:0];
                CFG_EXP_MIN:      cfg_reg.exp_min <= cfg_data[EXP_W-1:0];
                CFG_EXP_MAX:      cfg_reg.exp_max <= cfg_data[EXP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // pixel intake and accumulation
    mla_front #(
        .FRAME_ROWS  (FRAME_ROWS),
        .FRAME_COLS  (FRAME_COLS),
        .SAMPLE_STEP (SAMPLE_STEP),
        .RADIUS      (RADIUS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pix_row   (pix_row),
        .pix_col   (pix_col),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .frame_end (frame_end),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    // frame summary queue
    mla_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .count     (q_count)
    );

    // mean and exposure update
    mla_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .exposure     (exposure),
        .mean_luma    (mean_luma),
        .sample_count (sample_count)
    );

endmodule
